// ===== sv/uopc_pkg.sv =====
// Package with the types, widths and constants of the offset-point controller.
`default_nettype none
package uopc_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int MAX_ITER       = 24;
    localparam int CW             = 34;
    localparam int VW             = 33;
    localparam int PW             = CW + VW;
    localparam int SW             = PW + 1;
    localparam int DIVW           = SW - 22;
    localparam int DENW           = 16;
    localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

    localparam logic [15:0] GAIN_RESET   = 16'd256;
    localparam logic [15:0] OFFSET_RESET = 16'd64;
    localparam logic        REG_GAIN     = 1'b0;
    localparam logic        REG_OFFSET   = 1'b1;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
        logic signed [15:0] measured_x;
        logic signed [15:0] measured_y;
        logic [15:0]        heading;
    } in_t;

    typedef struct packed {
        logic signed [31:0] forward_speed;
        logic signed [31:0] turn_rate;
        logic               singular;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic                 flip;
    } cordic_t;

    typedef struct packed {
        logic [DENW-1:0]    rem;
        logic [DIVW-1:0]    nq;
        logic               neg;
        logic               sing;
        logic signed [31:0] v;
        logic               clipv;
    } div_t;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0:       r = 32'd536870912;
            1:       r = 32'd316933406;
            2:       r = 32'd167458907;
            3:       r = 32'd85004756;
            4:       r = 32'd42667331;
            5:       r = 32'd21354465;
            6:       r = 32'd10679838;
            7:       r = 32'd5340245;
            8:       r = 32'd2670163;
            9:       r = 32'd1335087;
            10:      r = 32'd667544;
            11:      r = 32'd333772;
            12:      r = 32'd166886;
            13:      r = 32'd83443;
            14:      r = 32'd41722;
            15:      r = 32'd20861;
            16:      r = 32'd10430;
            17:      r = 32'd5215;
            18:      r = 32'd2608;
            19:      r = 32'd1304;
            20:      r = 32'd652;
            21:      r = 32'd326;
            22:      r = 32'd163;
            23:      r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/uopc_cordic_cell.sv =====
// One CORDIC rotation cell with its pipeline register.
`default_nettype none
module uopc_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   en,
    input  wire                   in_valid,
    input  uopc_pkg::cordic_t     in_data,
    output logic                  out_valid,
    output uopc_pkg::cordic_t     out_data
);

    localparam logic signed [uopc_pkg::CW-1:0] ATAN =
        uopc_pkg::CW'(uopc_pkg::atan_turn(IDX));

    logic              valid_reg;
    uopc_pkg::cordic_t data_reg;
    uopc_pkg::cordic_t data_next;

    always_comb begin
        data_next = in_data;
        if (!in_data.z[uopc_pkg::CW-1]) begin
            data_next.x = in_data.x - (in_data.y >>> IDX);
            data_next.y = in_data.y + (in_data.x >>> IDX);
            data_next.z = in_data.z - ATAN;
        end else begin
            data_next.x = in_data.x + (in_data.y >>> IDX);
            data_next.y = in_data.y - (in_data.x >>> IDX);
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== sv/uopc_div_cell.sv =====
// One restoring-division cell that produces one quotient bit per stage.
`default_nettype none
module uopc_div_cell (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             en,
    input  wire  [uopc_pkg::DENW-1:0]       den,
    input  wire                             in_valid,
    input  uopc_pkg::div_t                  in_data,
    output logic                            out_valid,
    output uopc_pkg::div_t                  out_data
);

    logic           valid_reg;
    uopc_pkg::div_t data_reg;
    uopc_pkg::div_t data_next;
    logic [uopc_pkg::DENW:0] trial;
    logic [uopc_pkg::DENW:0] diff;
    logic                    ge;

    always_comb begin
        trial     = {in_data.rem, in_data.nq[uopc_pkg::DIVW-1]};
        diff      = trial - {1'b0, den};
        ge        = (trial >= {1'b0, den});
        data_next = in_data;
        data_next.rem = ge ? diff[uopc_pkg::DENW-1:0] : trial[uopc_pkg::DENW-1:0];
        data_next.nq  = {in_data.nq[uopc_pkg::DIVW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== sv/unicycle_offset_point_controller.sv =====
// Top level of the offset-point controller: CORDIC chain, products and divider chain.
//
// Channel   Direction  Handshake             Payload
// s_        in         s_valid / s_ready     uopc_pkg::in_t (target, measured, heading)
// m_        out        m_valid / m_ready     uopc_pkg::out_t (speed, turn rate, flags)
// APB       in/out     psel/penable/pready   gain at 0x0, offset_distance at 0x4
//
// One transaction is accepted per cycle while the output is not stalled.
// Path: input register, ANGLE_BITS (at most 24) CORDIC cells, product register,
// divider register, DIVW divider cells and output register; divider cells are the bulk.
// The whole pipeline halts while m_valid is high and m_ready is low.
// Reset is synchronous and clears all valid bits and restores the register defaults.
`default_nettype none
module unicycle_offset_point_controller #(
    parameter int ANGLE_BITS = uopc_pkg::ANGLE_BITS_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  uopc_pkg::in_t       s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output uopc_pkg::out_t      m_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int ITERS = (ANGLE_BITS > uopc_pkg::MAX_ITER) ? uopc_pkg::MAX_ITER :
                           ((ANGLE_BITS < 1) ? 1 : ANGLE_BITS);
    localparam int DROP  = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
    localparam logic [15:0] HMASK = 16'(17'h0FFFF << DROP);
    localparam int CW   = uopc_pkg::CW;
    localparam int VW   = uopc_pkg::VW;
    localparam int PW   = uopc_pkg::PW;
    localparam int SW   = uopc_pkg::SW;
    localparam int DIVW = uopc_pkg::DIVW;

    logic [15:0] gain_reg;
    logic [15:0] offset_reg;
    logic        en;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == uopc_pkg::REG_OFFSET) ? {16'd0, offset_reg}
                                                        : {16'd0, gain_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= uopc_pkg::GAIN_RESET;
            offset_reg <= uopc_pkg::OFFSET_RESET;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == uopc_pkg::REG_GAIN) begin
                gain_reg <= pwdata[15:0];
            end else begin
                offset_reg <= pwdata[15:0];
            end
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic signed [16:0]   ex;
    logic signed [16:0]   ey;
    logic signed [VW:0]   vx_full;
    logic signed [VW:0]   vy_full;
    logic [31:0]          ang;
    logic [31:0]          ang_t;
    logic [31:0]          ang_r;
    uopc_pkg::cordic_t    c0_next;

    always_comb begin
        ex      = 17'(s_data.target_x) - 17'(s_data.measured_x);
        ey      = 17'(s_data.target_y) - 17'(s_data.measured_y);
        vx_full = $signed({1'b0, gain_reg}) * ex;
        vy_full = $signed({1'b0, gain_reg}) * ey;
        ang     = {s_data.heading & HMASK, 16'd0};
        ang_t   = ang + 32'h4000_0000;
        ang_r   = ang_t[31] ? (ang + 32'h8000_0000) : ang;
        c0_next.x    = uopc_pkg::CORDIC_K;
        c0_next.y    = '0;
        c0_next.z    = CW'($signed(ang_r));
        c0_next.vx   = vx_full[VW-1:0];
        c0_next.vy   = vy_full[VW-1:0];
        c0_next.flip = ang_t[31];
    end

    uopc_pkg::cordic_t cd [0:ITERS];
    logic              cv [0:ITERS];
    uopc_pkg::cordic_t c0_reg;
    logic              c0_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_valid_reg <= 1'b0;
        end else if (en) begin
            c0_valid_reg <= s_valid;
        end
        if (en) begin
            c0_reg <= c0_next;
        end
    end

    assign cd[0] = c0_reg;
    assign cv[0] = c0_valid_reg;

    for (genvar i = 0; i < ITERS; i++) begin : g_cordic
        uopc_cordic_cell #(.IDX(i)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_data  (cd[i+1])
        );
    end

    logic signed [PW-1:0] xvx_reg;
    logic signed [PW-1:0] yvy_reg;
    logic signed [PW-1:0] xvy_reg;
    logic signed [PW-1:0] yvx_reg;
    logic                 flip_reg;
    logic                 mul_valid_reg;
    logic signed [PW-1:0] xc;
    logic signed [PW-1:0] yc;
    logic signed [PW-1:0] vxc;
    logic signed [PW-1:0] vyc;

    always_comb begin
        xc  = PW'(cd[ITERS].x);
        yc  = PW'(cd[ITERS].y);
        vxc = PW'(cd[ITERS].vx);
        vyc = PW'(cd[ITERS].vy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= cv[ITERS];
        end
        if (en) begin
            xvx_reg  <= xc * vxc;
            yvy_reg  <= yc * vyc;
            xvy_reg  <= xc * vyc;
            yvx_reg  <= yc * vxc;
            flip_reg <= cd[ITERS].flip;
        end
    end

    logic signed [SW-1:0] vsum;
    logic signed [SW-1:0] vacc;
    logic signed [SW-1:0] vsh;
    logic signed [SW-1:0] nsum;
    logic [SW-1:0]        nmag;
    uopc_pkg::div_t       d0_next;

    always_comb begin
        vsum = SW'(xvx_reg) + SW'(yvy_reg);
        nsum = SW'(xvy_reg) - SW'(yvx_reg);
        if (flip_reg) begin
            vsum = -vsum;
            nsum = -nsum;
        end
        vacc = vsum + SW'(64'sd536870912);
        vsh  = vacc >>> 30;
        nmag = nsum[SW-1] ? SW'(-nsum) : SW'(nsum);
        d0_next.rem  = '0;
        d0_next.nq   = nmag[SW-1:22];
        d0_next.neg  = nsum[SW-1];
        d0_next.sing = (offset_reg == 16'd0);
        if (vsh > SW'(64'sd2147483647)) begin
            d0_next.v     = 32'sh7FFF_FFFF;
            d0_next.clipv = 1'b1;
        end else if (vsh < -SW'(64'sd2147483648)) begin
            d0_next.v     = 32'sh8000_0000;
            d0_next.clipv = 1'b1;
        end else begin
            d0_next.v     = vsh[31:0];
            d0_next.clipv = 1'b0;
        end
    end

    uopc_pkg::div_t dd [0:DIVW];
    logic           dv [0:DIVW];
    uopc_pkg::div_t d0_reg;
    logic           d0_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_valid_reg <= 1'b0;
        end else if (en) begin
            d0_valid_reg <= mul_valid_reg;
        end
        if (en) begin
            d0_reg <= d0_next;
        end
    end

    assign dd[0] = d0_reg;
    assign dv[0] = d0_valid_reg;

    for (genvar j = 0; j < DIVW; j++) begin : g_div
        uopc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .den       (offset_reg),
            .in_valid  (dv[j]),
            .in_data   (dd[j]),
            .out_valid (dv[j+1]),
            .out_data  (dd[j+1])
        );
    end

    uopc_pkg::out_t out_next;
    uopc_pkg::out_t out_reg;
    logic           out_valid_reg;
    logic [DIVW-1:0] q;
    logic           clipw;

    always_comb begin
        q     = dd[DIVW].nq;
        clipw = 1'b0;
        if (dd[DIVW].sing) begin
            out_next.turn_rate = '0;
        end else if (!dd[DIVW].neg) begin
            if (q > DIVW'(64'd2147483647)) begin
                out_next.turn_rate = 32'sh7FFF_FFFF;
                clipw              = 1'b1;
            end else begin
                out_next.turn_rate = q[31:0];
            end
        end else begin
            if (q > DIVW'(64'd2147483648)) begin
                out_next.turn_rate = 32'sh8000_0000;
                clipw              = 1'b1;
            end else begin
                out_next.turn_rate = -q[31:0];
            end
        end
        out_next.forward_speed = dd[DIVW].v;
        out_next.singular      = dd[DIVW].sing;
        out_next.saturated     = dd[DIVW].clipv || clipw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv[DIVW];
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.singular) |-> (m_data.turn_rate == 32'sd0))
        else $error("turn rate not zero on a singular result");
    a_sing_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.singular == (offset_reg == 16'd0)))
        else $error("singular flag disagrees with offset distance");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while output is empty");
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

// ===== dv/uopc_checker.sv =====
// Checker for the offset-point controller: watches both channels and the register port.
`timescale 1ns / 1ps
module uopc_checker #(
    parameter int ANGLE_BITS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    input  wire                 s_ready,
    input  uopc_pkg::in_t       s_data,
    input  wire                 m_valid,
    input  wire                 m_ready,
    input  uopc_pkg::out_t      m_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    input  wire                 pready,
    output int                  fail_count,
    output int                  commands_pending,
    output int                  commands_seen,
    output int                  singular_seen,
    output int                  clipped_seen
);

    localparam longint UNIT_GAIN = 652032874;
    localparam longint ARC_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    logic [15:0]     gain_k;
    logic [15:0]     offset_d;
    uopc_pkg::out_t  command_queue[$];

    function automatic uopc_pkg::out_t predict_command(uopc_pkg::in_t p, logic [15:0] k,
                                                       logic [15:0] d);
        longint vx, vy, x, y, z, xs, ys, acc, v, w, num, den;
        logic [31:0] a;
        logic [15:0] mask;
        bit flip, clip;
        int drop, iters;
        uopc_pkg::out_t r;
        drop  = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
        iters = (ANGLE_BITS > 24) ? 24 : ((ANGLE_BITS < 1) ? 1 : ANGLE_BITS);
        vx = longint'(k) * (longint'(p.target_x) - longint'(p.measured_x));
        vy = longint'(k) * (longint'(p.target_y) - longint'(p.measured_y));
        mask = 16'hFFFF << drop;
        a = {p.heading & mask, 16'h0000};
        flip = 1'b0;
        if (((a + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            a = a + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'(signed'(a));
        x = UNIT_GAIN;
        y = 0;
        for (int i = 0; i < iters; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ARC_TURNS[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ARC_TURNS[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        clip = 1'b0;
        acc = x * vx + y * vy + (64'sd1 <<< 29);
        v = acc >>> 30;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647; clip = 1'b1;
        end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648; clip = 1'b1;
        end
        w = 0;
        r.singular = (d == 16'd0);
        if (d != 16'd0) begin
            num = x * vy - y * vx;
            den = longint'(d) <<< 22;
            w = num / den;
            if (w > 64'sd2147483647) begin
                w = 64'sd2147483647; clip = 1'b1;
            end else if (w < -64'sd2147483648) begin
                w = -64'sd2147483648; clip = 1'b1;
            end
        end
        r.forward_speed = v[31:0];
        r.turn_rate     = w[31:0];
        r.saturated     = clip;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %0h, expected %0h", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        uopc_pkg::out_t want;
        if (!aresetn) begin
            gain_k   <= uopc_pkg::GAIN_RESET;
            offset_d <= uopc_pkg::OFFSET_RESET;
            command_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == 3'd0) gain_k <= pwdata[15:0];
                else if (paddr == 3'd4) offset_d <= pwdata[15:0];
            end
            if (s_valid && s_ready)
                command_queue.push_back(predict_command(s_data, gain_k, offset_d));
            if (m_valid && m_ready) begin
                commands_seen++;
                if (m_data.singular) singular_seen++;
                if (m_data.saturated) clipped_seen++;
                if (command_queue.size() == 0) begin
                    $display("[%0t] result transaction with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = command_queue.pop_front();
                    if (m_data.forward_speed !== want.forward_speed)
                        report_mismatch("forward_speed", m_data.forward_speed,
                                        want.forward_speed);
                    if (m_data.turn_rate !== want.turn_rate)
                        report_mismatch("turn_rate", m_data.turn_rate, want.turn_rate);
                    if (m_data.singular !== want.singular)
                        report_mismatch("singular", m_data.singular, want.singular);
                    if (m_data.saturated !== want.saturated)
                        report_mismatch("saturated", m_data.saturated, want.saturated);
                end
            end
        end
        commands_pending = command_queue.size();
    end

    initial begin
        fail_count       = 0;
        commands_pending = 0;
        commands_seen    = 0;
        singular_seen    = 0;
        clipped_seen     = 0;
    end
endmodule

// ===== dv/unicycle_offset_point_controller_tb.sv =====
// Testbench top for the offset-point controller: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module unicycle_offset_point_controller_tb;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    uopc_pkg::in_t   s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    uopc_pkg::out_t  m_data;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    int fail_count, commands_pending, commands_seen, singular_seen, clipped_seen;
    int burst_left = 0;
    int long_hold_req = 0;

    unicycle_offset_point_controller dut (.*);

    uopc_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready), .fail_count(fail_count),
        .commands_pending(commands_pending), .commands_seen(commands_seen),
        .singular_seen(singular_seen), .clipped_seen(clipped_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        int stall_mode;
        int hold_left;
        stall_mode = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req != 0) begin
                hold_left = long_hold_req;
                long_hold_req = 0;
            end
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_mode == 0) begin
                m_ready <= 1'b1;
            end else if (stall_mode == 1) begin
                m_ready <= $urandom_range(0, 1);
            end else begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic send_pose(uopc_pkg::in_t pose);
        s_valid <= 1'b1;
        s_data  <= pose;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 1) == 1) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
        end
    endtask

    task automatic write_register(logic [2:0] addr, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (commands_pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    function automatic uopc_pkg::in_t random_pose();
        uopc_pkg::in_t p;
        p = uopc_pkg::in_t'(80'({$urandom, $urandom, $urandom}));
        if ($urandom_range(0, 2) == 0) begin
            p.target_x = p.measured_x + 16'($signed($urandom_range(0, 511)) - 256);
            p.target_y = p.measured_y + 16'($signed($urandom_range(0, 511)) - 256);
        end
        return p;
    endfunction

    initial begin
        logic [15:0] gain_set [6];
        logic [15:0] offset_set [6];
        logic [15:0] edge_headings [6];
        uopc_pkg::in_t p;
        gain_set   = '{16'd256, 16'd0, 16'd65535, 16'd300, 16'd1, 16'd4096};
        offset_set = '{16'd64, 16'd1, 16'd65535, 16'd0, 16'd1, 16'd200};
        edge_headings = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'd65535, 16'd8192};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values first, then poses at the field extremes and cardinal headings.
        foreach (edge_headings[i]) begin
            p = '{16'sd1000, -16'sd500, -16'sd200, 16'sd300, edge_headings[i]};
            send_pose(p);
        end
        send_pose('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'd12345});
        send_pose('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd40000});
        send_pose('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'hFFFF});
        send_pose('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0});
        send_pose('{16'sd77, 16'sd77, 16'sd77, 16'sd77, 16'd30000});
        send_pose('{-16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'd5000});
        drain_pipeline();

        for (int phase = 0; phase < 6; phase++) begin
            write_register(3'd0, gain_set[phase]);
            write_register(3'd4, offset_set[phase]);
            send_pose('{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'd9000});
            send_pose('{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'd60000});
            if (phase == 2) long_hold_req = 300;
            repeat (165) send_pose(random_pose());
            drain_pipeline();
        end

        $display("Covered %0d results (%0d singular, %0d clipped) over six gain/offset settings.",
                 commands_seen, singular_seen, clipped_seen);
        $display("Register extremes, cardinal headings and a long output stall were included.");
        if (fail_count == 0) begin
            $display("unicycle_offset_point_controller: match");
        end else begin
            $display("unicycle_offset_point_controller: mismatch");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("unicycle_offset_point_controller: mismatch");
        $finish;
    end
endmodule
